### src/acpm_pkg.sv
// shared types, constants and functions for the ctr/pmac engine
`default_nettype none
package acpm_pkg;

  localparam int AES_ROUNDS = 10;
  localparam int RK_WORDS = 2 * (AES_ROUNDS + 1);
  localparam int RND_W = $clog2(AES_ROUNDS + 1);
  localparam int RK_IDX_W = $clog2(RK_WORDS);

  localparam logic [2:0] REG_KEY_HI = 3'd0;
  localparam logic [2:0] REG_KEY_LO = 3'd1;
  localparam logic [2:0] REG_NONCE_HI = 3'd2;
  localparam logic [2:0] REG_NONCE_LO = 3'd3;
  localparam logic [2:0] REG_DECRYPT = 3'd4;
  localparam logic [2:0] REG_ETAG_HI = 3'd5;
  localparam logic [2:0] REG_ETAG_LO = 3'd6;

  localparam logic [7:0] GF_FOLD = 8'h87;

  typedef struct packed {
    logic         start;
    logic [127:0] din;
  } aes_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] dout;
  } aes_rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] r;
    unique case (x)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [RND_W-1:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
      4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
      4'd9: v = 8'h1b; 4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? {120'd0, GF_FOLD} : 128'd0);
  endfunction

endpackage
`default_nettype wire

### src/aes128_ctr_pmac_engine.sv
// top level: aes-128 counter mode with pmac-style tag over the ciphertext
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/ready   | block_hi, block_lo, last_block
//  out_    | output    | out_valid/ready  | result_kind, word_hi, word_lo, tag_match, run_end
//  cfg_    | input     | cfg_we           | cfg_index, cfg_data
//
//  one aes round unit does every encryption: a load step and ten rounds
//  a data item needs two encryptions before the next item is accepted
//  a last item needs a third encryption for the tag, then l = aes(0) again
//  after reset or a key write: key expansion, then l = aes(0)
//  an item is accepted only while idle with no result waiting; the tag waits for the data item
`default_nettype none
module aes128_ctr_pmac_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_block_hi,
  input  wire logic [63:0] in_block_lo,
  input  wire logic        in_last_block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [63:0]      out_word_hi,
  output logic [63:0]      out_word_lo,
  output logic             out_tag_match,
  output logic             out_run_end,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  typedef enum logic [2:0] {
    S_BOOT, S_LREQ, S_LWAIT, S_IDLE, S_KS, S_MAC, S_TAG, S_OUT
  } st_t;

  st_t          st_r;
  logic [63:0]  key_hi_r, key_lo_r, nonce_lo_r, etag_hi_r, etag_lo_r;
  logic [31:0]  nonce_hi_r;
  logic         dec_r;
  logic [127:0] mask_r, acc_r, blk_r;
  logic [31:0]  ctr_r;
  logic         fin_r, tag_pend_r, kx_r;
  logic         ov_r, kind_r, match_r, rend_r;
  logic [127:0] word_r;

  acpm_pkg::aes_req_t req;
  acpm_pkg::aes_rsp_t rsp;
  logic               key_wr;
  logic               ov_set;
  logic [127:0]       ks;
  logic [127:0]       mac_in;

  assign key_wr = cfg_we && (cfg_index == acpm_pkg::REG_KEY_HI ||
                             cfg_index == acpm_pkg::REG_KEY_LO);

  assign ov_set = !key_wr && (((st_r == S_IDLE) && tag_pend_r && (!ov_r || out_ready)) ||
                              ((st_r == S_KS) && rsp.done));

  acpm_aes_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .kx_start (kx_r),
    .key      ({key_hi_r, key_lo_r}),
    .req      (req),
    .rsp      (rsp)
  );

  assign ks     = rsp.dout;
  assign mac_in = dec_r ? blk_r : (blk_r ^ ks);

  always_comb begin
    req.start = 1'b0;
    req.din   = '0;
    unique case (st_r)
      S_LREQ: begin
        req.start = !rsp.busy;
      end
      S_IDLE: begin
        req.start = in_valid && in_ready;
        req.din   = {nonce_hi_r, nonce_lo_r, ctr_r};
      end
      S_KS: begin
        req.start = rsp.done;
        req.din   = mac_in ^ (fin_r ? acpm_pkg::gf_double(mask_r) : mask_r);
      end
      S_MAC: begin
        req.start = rsp.done && fin_r;
        req.din   = acc_r ^ ks;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  assign in_ready = (st_r == S_IDLE) && !tag_pend_r && !ov_r && !kx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_BOOT;
      key_hi_r   <= '0;
      key_lo_r   <= '0;
      nonce_hi_r <= '0;
      nonce_lo_r <= '0;
      dec_r      <= 1'b0;
      etag_hi_r  <= '0;
      etag_lo_r  <= '0;
      acc_r      <= '0;
      ctr_r      <= 32'd1;
      tag_pend_r <= 1'b0;
      kx_r       <= 1'b1;
      ov_r       <= 1'b0;
    end else begin
      kx_r <= key_wr;
      if (cfg_we) begin
        unique case (cfg_index)
          acpm_pkg::REG_KEY_HI:   key_hi_r   <= cfg_data;
          acpm_pkg::REG_KEY_LO:   key_lo_r   <= cfg_data;
          acpm_pkg::REG_NONCE_HI: nonce_hi_r <= cfg_data[31:0];
          acpm_pkg::REG_NONCE_LO: nonce_lo_r <= cfg_data;
          acpm_pkg::REG_DECRYPT:  dec_r      <= cfg_data[0];
          acpm_pkg::REG_ETAG_HI:  etag_hi_r  <= cfg_data;
          acpm_pkg::REG_ETAG_LO:  etag_lo_r  <= cfg_data;
          default: ;
        endcase
      end
      if (ov_set) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (key_wr) begin
        st_r       <= S_BOOT;
        acc_r      <= '0;
        ctr_r      <= 32'd1;
        tag_pend_r <= 1'b0;
      end else begin
        unique case (st_r)
          S_BOOT: st_r <= S_LREQ;
          S_LREQ: begin
            if (!rsp.busy) st_r <= S_LWAIT;
          end
          S_LWAIT: begin
            if (rsp.done) begin
              mask_r <= rsp.dout;
              st_r   <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (tag_pend_r) begin
              if (!ov_r || out_ready) begin
                kind_r     <= 1'b1;
                word_r     <= acc_r;
                match_r    <= dec_r && (acc_r == {etag_hi_r, etag_lo_r});
                rend_r     <= 1'b1;
                tag_pend_r <= 1'b0;
                acc_r      <= '0;
                ctr_r      <= 32'd1;
                st_r       <= S_BOOT;
              end
            end else if (in_valid && in_ready) begin
              blk_r <= {in_block_hi, in_block_lo};
              fin_r <= in_last_block;
              ctr_r <= ctr_r + 32'd1;
              st_r  <= S_KS;
            end
          end
          S_KS: begin
            if (rsp.done) begin
              kind_r  <= 1'b0;
              word_r  <= blk_r ^ ks;
              match_r <= 1'b0;
              rend_r  <= !fin_r;
              st_r    <= S_MAC;
            end
          end
          S_MAC: begin
            if (rsp.done) begin
              acc_r <= acc_r ^ ks;
              if (fin_r) begin
                st_r <= S_TAG;
              end else begin
                mask_r <= acpm_pkg::gf_double(mask_r);
                st_r   <= S_IDLE;
              end
            end
          end
          S_TAG: begin
            if (rsp.done) begin
              acc_r      <= ks;
              tag_pend_r <= 1'b1;
              st_r       <= S_IDLE;
            end
          end
          S_OUT: st_r <= S_IDLE;
          default: st_r <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_result_kind = kind_r;
  assign out_word_hi     = word_r[127:64];
  assign out_word_lo     = word_r[63:0];
  assign out_tag_match   = match_r;
  assign out_run_end     = rend_r;

endmodule
`default_nettype wire

### src/acpm_aes_core.sv
// iterative aes-128 round unit; the key schedule is expanded once per key load and stored in a round-key file
`default_nettype none
module acpm_aes_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              kx_start,
  input  wire logic [127:0]      key,
  input  wire acpm_pkg::aes_req_t req,
  output acpm_pkg::aes_rsp_t     rsp
);

  typedef enum logic [1:0] {S_IDLE, S_KEXP, S_ENC} st_t;

  st_t                           st_r;
  logic [acpm_pkg::RND_W-1:0]    rnd_r;
  logic [127:0]                  kst_r;
  logic [127:0]                  dat_r;
  logic                          done_r;
  logic [63:0]                   rk_mem [acpm_pkg::RK_WORDS];

  logic [127:0] kst_nxt;
  logic [127:0] rk_cur;
  logic [127:0] sb;
  logic [127:0] sr;
  logic [127:0] mc;
  logic [127:0] rnd_out;
  logic [31:0]  w0, w1, w2, w3, t;
  logic [acpm_pkg::RK_IDX_W-1:0] ia, ib;

  always_comb begin
    t  = acpm_pkg::sub_word({kst_r[23:0], kst_r[31:24]}) ^
         {acpm_pkg::rcon(rnd_r + acpm_pkg::RND_W'(1)), 24'd0};
    w0 = kst_r[127:96] ^ t;
    w1 = kst_r[95:64] ^ w0;
    w2 = kst_r[63:32] ^ w1;
    w3 = kst_r[31:0] ^ w2;
    kst_nxt = {w0, w1, w2, w3};
  end

  assign ia = acpm_pkg::RK_IDX_W'({rnd_r, 1'b0});
  assign ib = acpm_pkg::RK_IDX_W'({rnd_r, 1'b1});
  assign rk_cur = {rk_mem[ia], rk_mem[ib]};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[127-8*i -: 8] = acpm_pkg::sbox(dat_r[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[127-8*(c*4+i) -: 8] = sb[127-8*(((c+i)%4)*4+i) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sr[127-32*c -: 8];
      a1 = sr[119-32*c -: 8];
      a2 = sr[111-32*c -: 8];
      a3 = sr[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127-32*c -: 8] = a0 ^ al ^ acpm_pkg::xtime(a0 ^ a1);
      mc[119-32*c -: 8] = a1 ^ al ^ acpm_pkg::xtime(a1 ^ a2);
      mc[111-32*c -: 8] = a2 ^ al ^ acpm_pkg::xtime(a2 ^ a3);
      mc[103-32*c -: 8] = a3 ^ al ^ acpm_pkg::xtime(a3 ^ a0);
    end
    rnd_out = ((rnd_r == acpm_pkg::RND_W'(acpm_pkg::AES_ROUNDS)) ? sr : mc) ^ rk_cur;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_KEXP) begin
      rk_mem[ia] <= kst_r[127:64];
      rk_mem[ib] <= kst_r[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      rnd_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == S_ENC) && !kx_start &&
                (rnd_r == acpm_pkg::RND_W'(acpm_pkg::AES_ROUNDS));
      unique case (st_r)
        S_IDLE: begin
          if (kx_start) begin
            st_r  <= S_KEXP;
            rnd_r <= '0;
            kst_r <= key;
          end else if (req.start) begin
            st_r  <= S_ENC;
            rnd_r <= acpm_pkg::RND_W'(1);
            dat_r <= req.din ^ {rk_mem[0], rk_mem[1]};
          end
        end
        S_KEXP: begin
          if (kx_start) begin
            rnd_r <= '0;
            kst_r <= key;
          end else begin
            rnd_r <= rnd_r + acpm_pkg::RND_W'(1);
            kst_r <= kst_nxt;
            if (rnd_r == acpm_pkg::RND_W'(acpm_pkg::AES_ROUNDS)) begin
              st_r <= S_IDLE;
            end
          end
        end
        S_ENC: begin
          if (kx_start) begin
            st_r  <= S_KEXP;
            rnd_r <= '0;
            kst_r <= key;
          end else begin
            dat_r <= rnd_out;
            rnd_r <= rnd_r + acpm_pkg::RND_W'(1);
            if (rnd_r == acpm_pkg::RND_W'(acpm_pkg::AES_ROUNDS)) begin
              st_r <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.busy = (st_r != S_IDLE) || kx_start;
  assign rsp.done = done_r;
  assign rsp.dout = dat_r;

endmodule
`default_nettype wire

### dv/ctr_pmac_monitor.sv
// channel monitor with counter-mode/pmac prediction and result comparison
`timescale 1ns / 100ps
module ctr_pmac_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  input  logic        in_last_block,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_kind,
  input  logic [63:0] out_word_hi,
  input  logic [63:0] out_word_lo,
  input  logic        out_tag_match,
  input  logic        out_run_end,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic         kind;
    logic [127:0] word;
    logic         match;
    logic         last;
  } engine_result_t;

  logic [7:0] sbox_tab [256] = '{
    'h63,'h7c,'h77,'h7b,'hf2,'h6b,'h6f,'hc5,'h30,'h01,'h67,'h2b,'hfe,'hd7,'hab,'h76,
    'hca,'h82,'hc9,'h7d,'hfa,'h59,'h47,'hf0,'had,'hd4,'ha2,'haf,'h9c,'ha4,'h72,'hc0,
    'hb7,'hfd,'h93,'h26,'h36,'h3f,'hf7,'hcc,'h34,'ha5,'he5,'hf1,'h71,'hd8,'h31,'h15,
    'h04,'hc7,'h23,'hc3,'h18,'h96,'h05,'h9a,'h07,'h12,'h80,'he2,'heb,'h27,'hb2,'h75,
    'h09,'h83,'h2c,'h1a,'h1b,'h6e,'h5a,'ha0,'h52,'h3b,'hd6,'hb3,'h29,'he3,'h2f,'h84,
    'h53,'hd1,'h00,'hed,'h20,'hfc,'hb1,'h5b,'h6a,'hcb,'hbe,'h39,'h4a,'h4c,'h58,'hcf,
    'hd0,'hef,'haa,'hfb,'h43,'h4d,'h33,'h85,'h45,'hf9,'h02,'h7f,'h50,'h3c,'h9f,'ha8,
    'h51,'ha3,'h40,'h8f,'h92,'h9d,'h38,'hf5,'hbc,'hb6,'hda,'h21,'h10,'hff,'hf3,'hd2,
    'hcd,'h0c,'h13,'hec,'h5f,'h97,'h44,'h17,'hc4,'ha7,'h7e,'h3d,'h64,'h5d,'h19,'h73,
    'h60,'h81,'h4f,'hdc,'h22,'h2a,'h90,'h88,'h46,'hee,'hb8,'h14,'hde,'h5e,'h0b,'hdb,
    'he0,'h32,'h3a,'h0a,'h49,'h06,'h24,'h5c,'hc2,'hd3,'hac,'h62,'h91,'h95,'he4,'h79,
    'he7,'hc8,'h37,'h6d,'h8d,'hd5,'h4e,'ha9,'h6c,'h56,'hf4,'hea,'h65,'h7a,'hae,'h08,
    'hba,'h78,'h25,'h2e,'h1c,'ha6,'hb4,'hc6,'he8,'hdd,'h74,'h1f,'h4b,'hbd,'h8b,'h8a,
    'h70,'h3e,'hb5,'h66,'h48,'h03,'hf6,'h0e,'h61,'h35,'h57,'hb9,'h86,'hc1,'h1d,'h9e,
    'he1,'hf8,'h98,'h11,'h69,'hd9,'h8e,'h94,'h9b,'h1e,'h87,'he9,'hce,'h55,'h28,'hdf,
    'h8c,'ha1,'h89,'h0d,'hbf,'he6,'h42,'h68,'h41,'h99,'h2d,'h0f,'hb0,'h54,'hbb,'h16
  };

  logic [127:0] key_val;
  logic [95:0]  nonce_val;
  logic         decrypt_on;
  logic [127:0] tag_expect;
  logic [31:0]  key_words [44];
  logic [127:0] mask_val;
  logic [127:0] acc_val;
  logic [31:0]  ctr_val;
  engine_result_t expected_results [$];

  function automatic logic [7:0] mul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] dbl128(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
  endfunction

  function automatic void expand_key();
    logic [31:0] w;
    logic [7:0]  rc;
    rc = 8'h01;
    key_words[0] = key_val[127:96];
    key_words[1] = key_val[95:64];
    key_words[2] = key_val[63:32];
    key_words[3] = key_val[31:0];
    for (int i = 4; i < 44; i++) begin
      w = key_words[i-1];
      if (i % 4 == 0) begin
        w = {w[23:0], w[31:24]};
        w = {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
        w = w ^ {rc, 24'h0};
        rc = mul2(rc);
      end
      key_words[i] = key_words[i-4] ^ w;
    end
  endfunction

  function automatic logic [127:0] aes_enc(input logic [127:0] din);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] rk;
    logic [127:0] dout;
    logic [7:0]   a0, a1, a2, a3, al;
    rk = {key_words[0], key_words[1], key_words[2], key_words[3]};
    for (int i = 0; i < 16; i++) s[i] = din[127-8*i -: 8] ^ rk[127-8*i -: 8];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = sbox_tab[s[i]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c*4+i] = s[((c+i)&3)*4+i];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ al ^ mul2(a0 ^ a1);
          t[c*4+1] = a1 ^ al ^ mul2(a1 ^ a2);
          t[c*4+2] = a2 ^ al ^ mul2(a2 ^ a3);
          t[c*4+3] = a3 ^ al ^ mul2(a3 ^ a0);
        end
      end
      rk = {key_words[4*r], key_words[4*r+1], key_words[4*r+2], key_words[4*r+3]};
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) dout[127-8*i -: 8] = s[i];
    return dout;
  endfunction

  function automatic void restart_message();
    mask_val = aes_enc(128'h0);
    acc_val = '0;
    ctr_val = 32'd1;
  endfunction

  function automatic void encrypt_block(input logic [127:0] blk, input logic fin);
    engine_result_t r;
    logic [127:0] ct, macin, tag;
    ct = blk ^ aes_enc({nonce_val, ctr_val});
    macin = decrypt_on ? blk : ct;
    ctr_val = ctr_val + 32'd1;
    r = '{kind: 1'b0, word: ct, match: 1'b0, last: !fin};
    expected_results.push_back(r);
    if (!fin) begin
      acc_val ^= aes_enc(macin ^ mask_val);
      mask_val = dbl128(mask_val);
    end else begin
      acc_val ^= aes_enc(macin ^ dbl128(mask_val));
      tag = aes_enc(acc_val);
      r = '{kind: 1'b1, word: tag, match: decrypt_on && (tag == tag_expect), last: 1'b1};
      expected_results.push_back(r);
      restart_message();
    end
  endfunction

  always @(posedge clk) begin
    engine_result_t e;
    if (!rst_n) begin
      key_val = '0; nonce_val = '0; decrypt_on = 1'b0; tag_expect = '0;
      expected_results.delete();
      mismatches = 0;
      expand_key();
      restart_message();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          acpm_pkg::REG_KEY_HI: begin
            key_val[127:64] = cfg_data; expand_key(); restart_message();
          end
          acpm_pkg::REG_KEY_LO: begin
            key_val[63:0] = cfg_data; expand_key(); restart_message();
          end
          acpm_pkg::REG_NONCE_HI: nonce_val[95:64] = cfg_data[31:0];
          acpm_pkg::REG_NONCE_LO: nonce_val[63:0] = cfg_data;
          acpm_pkg::REG_DECRYPT:  decrypt_on = cfg_data[0];
          acpm_pkg::REG_ETAG_HI:  tag_expect[127:64] = cfg_data;
          acpm_pkg::REG_ETAG_LO:  tag_expect[63:0] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: kind %0d word %h", $realtime,
                     out_result_kind, {out_word_hi, out_word_lo});
        end else begin
          e = expected_results.pop_front();
          if (e.kind !== out_result_kind || e.word !== {out_word_hi, out_word_lo} ||
              e.match !== out_tag_match || e.last !== out_run_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected kind %0d word %h match %0d end %0d",
                       $realtime, e.kind, e.word, e.match, e.last);
              $display("%0t:          actual   kind %0d word %h match %0d end %0d",
                       $realtime, out_result_kind, {out_word_hi, out_word_lo},
                       out_tag_match, out_run_end);
            end
          end
        end
      end
      if (in_valid && in_ready)
        encrypt_block({in_block_hi, in_block_lo}, in_last_block);
    end
    pending = expected_results.size();
  end

endmodule

### dv/testbench.sv
// top of the engine testbench: clock, reset, stimulus, output pacing and verdict
`timescale 1ns / 100ps
module testbench;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_block_hi = '0;
  logic [63:0] in_block_lo = '0;
  logic        in_last_block = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [63:0] out_word_hi;
  logic [63:0] out_word_lo;
  logic        out_tag_match;
  logic        out_run_end;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          mismatches;
  int          pending;

  int           blocks_sent, messages_sent, tags_seen, matches_seen;
  int           burst_left, stall_left, rx_mode, rx_cycle;
  logic [127:0] last_tag;
  logic [127:0] cipher_q [$];

  aes128_ctr_pmac_engine DUT (.*);
  ctr_pmac_monitor monitor (.*);

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("[aes128_ctr_pmac_engine] ERROR");
    $finish;
  end

  // receiver stall pattern; the mode is redrawn at random among three
  always @(negedge clk) begin
    logic rdy;
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (rx_mode == 0) begin
      rdy = 1'b1;
    end else begin
      if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(1, 20);
      rdy = (rx_mode == 1) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
    end
    out_ready = rdy;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_result_kind == 1'b0) begin
        cipher_q.push_back({out_word_hi, out_word_lo});
      end else begin
        last_tag = {out_word_hi, out_word_lo};
        tags_seen++;
        if (out_tag_match) matches_seen++;
      end
    end
  end

  task automatic send_block(input logic [127:0] blk, input logic fin, input bit paced);
    if (paced) begin
      if (burst_left == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
    end
    in_valid = 1'b1;
    {in_block_hi, in_block_lo} = blk;
    in_last_block = fin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    blocks_sent++;
    if (fin) messages_sent++;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_message(input int len, input bit paced);
    for (int i = 0; i < len; i++) send_block({rand64(), rand64()}, i == len - 1, paced);
  endtask

  // capture a message's ciphertext and tag, then feed it back in decrypt mode
  task automatic tag_check_round(input int len, input bit corrupt);
    logic [127:0] ct [$];
    wait_idle();
    cfg_write(acpm_pkg::REG_DECRYPT, 64'h2);
    cipher_q.delete();
    send_message(len, 1'b0);
    wait_idle();
    ct = cipher_q;
    cfg_write(acpm_pkg::REG_ETAG_HI, last_tag[127:64]);
    cfg_write(acpm_pkg::REG_ETAG_LO, last_tag[63:0] ^ {63'h0, corrupt});
    cfg_write(acpm_pkg::REG_DECRYPT, 64'h1);
    for (int i = 0; i < ct.size(); i++) send_block(ct[i], i == ct.size() - 1, 1'b1);
    wait_idle();
  endtask

  initial begin
    int len;
    blocks_sent = 0; messages_sent = 0; tags_seen = 0; matches_seen = 0;
    burst_left = 0; stall_left = 0; rx_mode = 0; rx_cycle = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset key, extreme blocks
    send_block('0, 1'b1, 1'b0);
    send_block('1, 1'b0, 1'b0);
    send_block({64'h0, 64'hffff_ffff_ffff_ffff}, 1'b0, 1'b0);
    send_block({64'hffff_ffff_ffff_ffff, 64'h0}, 1'b1, 1'b0);
    wait_idle();
    cfg_write(acpm_pkg::REG_KEY_HI, '1);
    cfg_write(acpm_pkg::REG_KEY_LO, '1);
    cfg_write(acpm_pkg::REG_NONCE_HI, '1);
    cfg_write(acpm_pkg::REG_NONCE_LO, '1);
    cfg_write(acpm_pkg::REG_ETAG_HI, '1);
    cfg_write(acpm_pkg::REG_ETAG_LO, '1);
    cfg_write(REG_UNUSED, '1);
    send_message(2, 1'b0);
    tag_check_round(2, 1'b0);
    tag_check_round(1, 1'b1);
    cfg_write(acpm_pkg::REG_DECRYPT, '0);
    // key changed in the middle of a message
    send_block('1, 1'b0, 1'b0);
    wait_idle();
    cfg_write(acpm_pkg::REG_KEY_HI, '0);
    send_block('1, 1'b1, 1'b0);
    // nonce changed in the middle of a message
    send_block({rand64(), rand64()}, 1'b0, 1'b0);
    wait_idle();
    cfg_write(acpm_pkg::REG_NONCE_LO, {$urandom, $urandom});
    send_block({rand64(), rand64()}, 1'b1, 1'b0);
    wait_idle();

    while (blocks_sent < 620) begin
      case ($urandom_range(0, 9))
        0: begin
          wait_idle();
          repeat ($urandom_range(1, 4))
            cfg_write(3'($urandom_range(0, 7)), rand64());
        end
        1: tag_check_round($urandom_range(1, 4), $urandom_range(0, 2) == 0);
        2: begin
          // message split by an idle gap and a nonce or mode write
          send_message($urandom_range(1, 3), 1'b1);
          send_block({rand64(), rand64()}, 1'b0, 1'b1);
          wait_idle();
          cfg_write(3'($urandom_range(2, 4)), rand64());
          send_message($urandom_range(1, 3), 1'b1);
        end
        default: begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
          send_message(len, 1'b1);
        end
      endcase
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("sent %0d blocks in %0d messages", blocks_sent, messages_sent);
    $display("received %0d tags, %0d with a tag match", tags_seen, matches_seen);
    if (mismatches == 0 && pending == 0)
      $display("[aes128_ctr_pmac_engine] OK");
    else
      $display("[aes128_ctr_pmac_engine] ERROR");
    $finish;
  end

endmodule

### sim.f
src/acpm_pkg.sv
src/acpm_aes_core.sv
src/aes128_ctr_pmac_engine.sv
dv/ctr_pmac_monitor.sv
dv/testbench.sv
